// ===== sv/utf8sp_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8sp_pkg
// Types, byte-range constants and decode helpers for the UTF-8 stream packer.
// ----------------------------------------------------------------------------
package utf8sp_pkg;

   // Byte-range limits from the UTF-8 encoding table.
   localparam logic [7:0] ASCII_MAX   = 8'h7F;
   localparam logic [7:0] LEAD2_MIN   = 8'hC2;
   localparam logic [7:0] LEAD2_MAX   = 8'hDF;
   localparam logic [7:0] LEAD3_MIN   = 8'hE0;
   localparam logic [7:0] LEAD3_MAX   = 8'hEF;
   localparam logic [7:0] LEAD3_SURR  = 8'hED;
   localparam logic [7:0] LEAD4_MIN   = 8'hF0;
   localparam logic [7:0] LEAD4_MAX   = 8'hF4;
   localparam logic [7:0] E0_CONT_MIN = 8'hA0;
   localparam logic [7:0] F0_CONT_MIN = 8'h90;
   localparam logic [7:0] F4_CONT_MAX = 8'h8F;
   localparam logic [7:0] CONT_MIN    = 8'h80;
   localparam logic [7:0] CONT_MAX    = 8'hBF;

   // Request kinds carried on tuser.
   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // Most results one request can cause.
   localparam int unsigned MAX_RESULTS = 4;

   // Sequence-gathering state: held lead and continuation bytes.
   typedef struct packed {
      logic [2:0][7:0] held_bytes;
      logic [1:0]      held_count;
      logic [2:0]      expected_length;
   } state_type;

   // One result item.
   typedef struct packed {
      logic        last_of_run;
      logic        valid_sequence;
      logic [2:0]  byte_count;
      logic [31:0] packed_char;
   } result_type;

   // All results caused by one request, entry 0 first.
   typedef struct packed {
      logic [2:0]            num;
      result_type [3:0]      res;
   } result_list_type;

   // Sequence length started by a lead byte; zero means it stands alone.
   function automatic logic [2:0] lead_length(input logic [7:0] b, input logic strict);
      logic [2:0] len;
      len = 3'd0;
      if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
         len = 3'd2;
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX && !(strict && b == LEAD3_SURR)) begin
         len = 3'd3;
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
         len = 3'd4;
      end
      return len;
   endfunction

   // Range check for a continuation byte at a given position after the lead.
   function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (pos == 2'd1) begin
         if (lead == LEAD3_MIN) begin
            lo = E0_CONT_MIN;
         end else if (lead == LEAD4_MIN) begin
            lo = F0_CONT_MIN;
         end else if (lead == LEAD4_MAX) begin
            hi = F4_CONT_MAX;
         end
      end
      return (b >= lo) && (b <= hi);
   endfunction

endpackage

// ===== sv/utf8sp_decode.sv =====
// ----------------------------------------------------------------------------
// utf8sp_decode
// Combinational step: from the held state and one request, forms the next
// state and the list of results that the request causes.
// ----------------------------------------------------------------------------
module utf8sp_decode (
   input  logic                        strict_mode,
   input  logic                        kind,
   input  logic [7:0]                  data_byte,
   input  utf8sp_pkg::state_type       cur_state,
   output utf8sp_pkg::state_type       nxt_state,
   output utf8sp_pkg::result_list_type results
);
   import utf8sp_pkg::*;

   logic [2:0]  lead_len;
   logic        lead_emits;
   result_type  lead_res;
   logic        cont_good;
   logic [2:0]  held_plus_one;
   logic [31:0] packed_word;

   // Lead classification and the result a standalone lead byte produces.
   always_comb begin
      lead_len                = lead_length(data_byte, strict_mode);
      lead_emits              = (lead_len == 3'd0);
      lead_res.last_of_run    = 1'b0;
      lead_res.valid_sequence = (data_byte <= ASCII_MAX);
      lead_res.byte_count     = 3'd1;
      lead_res.packed_char    = {24'd0, data_byte};
   end

   // Continuation check and packing of a completed sequence.
   always_comb begin
      cont_good     = cont_ok(cur_state.held_bytes[0], cur_state.held_count, data_byte);
      held_plus_one = {1'b0, cur_state.held_count} + 3'd1;
      packed_word   = '0;
      case (cur_state.held_count)
         2'd1: begin
            packed_word = {16'd0, data_byte, cur_state.held_bytes[0]};
         end
         2'd2: begin
            packed_word = {8'd0, data_byte, cur_state.held_bytes[1],
                           cur_state.held_bytes[0]};
         end
         2'd3: begin
            packed_word = {data_byte, cur_state.held_bytes[2],
                           cur_state.held_bytes[1], cur_state.held_bytes[0]};
         end
         default: begin
            packed_word = {24'd0, data_byte};
         end
      endcase
   end

   // Main decision: flush or break a sequence, take a lead, extend or complete a sequence.
   always_comb begin
      nxt_state   = cur_state;
      results.num = 3'd0;
      results.res = '0;

      if (kind == KIND_FLUSH || (cur_state.held_count != 2'd0 && !cont_good)) begin
         // Held bytes go out one by one as lone invalid bytes.
         for (int i = 0; i < 3; i++) begin
            if (i < int'(cur_state.held_count)) begin
               results.res[i].valid_sequence = 1'b0;
               results.res[i].byte_count     = 3'd1;
               results.res[i].packed_char    = {24'd0, cur_state.held_bytes[i]};
            end
         end
         results.num               = {1'b0, cur_state.held_count};
         nxt_state.held_count      = 2'd0;
         nxt_state.expected_length = 3'd0;
         // A failing byte is then taken again as a lead.
         if (kind == KIND_DATA) begin
            if (lead_emits) begin
               results.res[cur_state.held_count] = lead_res;
               results.num = held_plus_one;
            end else begin
               nxt_state.held_bytes[0]   = data_byte;
               nxt_state.held_count      = 2'd1;
               nxt_state.expected_length = lead_len;
            end
         end
      end else if (cur_state.held_count == 2'd0) begin
         if (lead_emits) begin
            results.res[0] = lead_res;
            results.num    = 3'd1;
         end else begin
            nxt_state.held_bytes[0]   = data_byte;
            nxt_state.held_count      = 2'd1;
            nxt_state.expected_length = lead_len;
         end
      end else if (held_plus_one >= cur_state.expected_length) begin
         results.res[0].valid_sequence = 1'b1;
         results.res[0].byte_count     = held_plus_one;
         results.res[0].packed_char    = packed_word;
         results.num                   = 3'd1;
         nxt_state.held_count          = 2'd0;
         nxt_state.expected_length     = 3'd0;
      end else begin
         nxt_state.held_bytes[cur_state.held_count] = data_byte;
         nxt_state.held_count = cur_state.held_count + 2'd1;
      end

      // Mark the final result of this request.
      for (int i = 0; i < MAX_RESULTS; i++) begin
         results.res[i].last_of_run = (3'(i) + 3'd1 == results.num);
      end
   end

endmodule

// ===== sv/utf8sp_out_queue.sv =====
// ----------------------------------------------------------------------------
// utf8sp_out_queue
// Result register: holds one request's results and hands them out one per
// cycle while popped, taking the next request's results as the last leaves.
// ----------------------------------------------------------------------------
module utf8sp_out_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  utf8sp_pkg::result_list_type load_list,
   input  logic                        pop,
   output logic                        can_load,
   output logic                        head_valid,
   output utf8sp_pkg::result_type      head
);
   import utf8sp_pkg::*;

   result_type [3:0] entry_ff;
   result_type [3:0] entry_in;
   logic [2:0]       count_ff;
   logic [2:0]       count_in;

   // Room for a new list once the buffer is empty or its last entry leaves.
   assign can_load   = (count_ff == 3'd0) || (count_ff == 3'd1 && pop);
   assign head_valid = (count_ff != 3'd0);
   assign head       = entry_ff[0];

   // Load, shift down on a pop, or hold.
   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = load_list.res;
         count_in = load_list.num;
      end else if (pop) begin
         for (int i = 0; i < 3; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/utf8_stream_packer.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_packer
// Gathers UTF-8 sequences of one to four bytes from a byte stream and emits
// each as one packed word; broken sequences come out as lone invalid bytes.
// ----------------------------------------------------------------------------
// The first result of a request is registered and shows in the cycle after it is accepted.
// Throughput: one request per cycle while each causes at most one result and
// the result channel is not stalled; a request causing N results holds the
// input off while the result register drains, one result per cycle while rsp_tready is high.
// Reset: clears the held-byte count, the sequence length and strict_mode;
// held byte values are left as they are.
module utf8_stream_packer (
   input  logic        clock,
   input  logic        reset,
   // Configuration: strict_mode.
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] kind
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] packed_char, [34:32] byte_count, rest zero
   output logic        rsp_tuser,   // [0] valid_sequence
   output logic        rsp_tlast    // last_of_run
);
   import utf8sp_pkg::*;

   logic            strict_ff;
   state_type       state_ff;
   state_type       state_in;
   result_list_type results;
   result_type      head;
   logic            accept;
   logic            can_load;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   // Strict-mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= 1'b0;
      end else if (csr_wr_en) begin
         strict_ff <= csr_wr_data;
      end
   end

   // Sequence decode for the request on the input.
   utf8sp_decode u_decode (
      .strict_mode (strict_ff),
      .kind        (req_tuser),
      .data_byte   (req_tdata),
      .cur_state   (state_ff),
      .nxt_state   (state_in),
      .results     (results)
   );

   // Held-sequence state; counts are cleared, held byte values are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.held_count      <= 2'd0;
         state_ff.expected_length <= 3'd0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Result register and drain.
   utf8sp_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .load_list  (results),
      .pop        (rsp_tvalid && rsp_tready),
      .can_load   (can_load),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {5'd0, head.byte_count, head.packed_char};
   assign rsp_tuser = head.valid_sequence;
   assign rsp_tlast = head.last_of_run;

endmodule
